FILE: rtl/mm_pkg.sv
`default_nettype none

package mm_pkg;

  // Command codes of an input item
  localparam logic [1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [1:0] CMD_COMPUTE = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ROWS_A    = 2'd0;
  localparam logic [1:0] REG_INNER_DIM = 2'd1;
  localparam logic [1:0] REG_COLS_B    = 2'd2;

  localparam int DimRegW = 4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [2:0]         row_index;
    logic [2:0]         col_index;
    logic signed [31:0] elem_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] out_value;
    logic               last;
  } out_item_t;

  // Tags that travel with a pair of operands through the MAC pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/matrix_multiply.sv
`default_nettype none

// Dense matrix multiply C = A * B in signed Q16.16. A load transfer (cmd load A or load B)
// writes one element into its store; loads outside the store and undefined commands are
// dropped without a result. A compute transfer emits every element of C in row-major
// order, last set on the final one. Each element reads A and B at one term per cycle
// through the single read port of each memory, then passes the registered read, the one
// shared 32x32 multiplier and the accumulator before the rounded and saturated value
// reaches the output register. The input side is not ready until a compute run has
// finished. Dimension registers are used as 1 when written as zero and capped at
// min(MAX_DIM, 8). The stores are not cleared at reset: read only elements that were
// loaded. Configuration writes are always accepted and should be made while idle.

module matrix_multiply #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire mm_pkg::in_item_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output mm_pkg::out_item_t      out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [3:0]        cfg_data_i
);

  import mm_pkg::*;

  localparam int CAP   = (MAX_DIM < 8) ? MAX_DIM : 8;
  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int DIM_W = $clog2(CAP + 1);
  localparam int DEPTH = CAP * CAP;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // 64-bit products, CAP of them, plus a spare sign bit
  localparam int ACC_W = 64 + $clog2(CAP) + 1;
  localparam logic [DimRegW-1:0] CapReg = DimRegW'(CAP);

  // Map a dimension register onto the range 1..CAP
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DimRegW-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > CapReg) begin
      r = DIM_W'(CAP);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  state_e state_q, state_d;

  logic [DimRegW-1:0] rows_a_q, inner_dim_q, cols_b_q;
  logic [DIM_W-1:0]   nr_q, nk_q, nc_q;
  logic [IDX_W-1:0]   i_q, j_q, k_q;
  mac_ctrl_t          rd_ctrl_q;
  out_item_t          out_q;

  logic in_xfer, out_xfer, start, load_ok;
  logic k_last, j_last, i_last;
  logic rd_en;
  logic we_a, we_b;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [31:0]   rdata_a, rdata_b;
  logic          mac_done;
  logic signed [31:0] mac_result;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign start    = in_xfer && (in_data_i.cmd == CMD_COMPUTE);

  assign k_last = (DIM_W'(k_q) + DIM_W'(1)) == nk_q;
  assign j_last = (DIM_W'(j_q) + DIM_W'(1)) == nc_q;
  assign i_last = (DIM_W'(i_q) + DIM_W'(1)) == nr_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DimRegW'(1);
      inner_dim_q <= DimRegW'(1);
      cols_b_q    <= DimRegW'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        REG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Loads: drop anything outside the store
  assign load_ok = ({1'b0, in_data_i.row_index} < CapReg) &&
                   ({1'b0, in_data_i.col_index} < CapReg);
  assign we_a    = in_xfer && load_ok && (in_data_i.cmd == CMD_LOAD_A);
  assign we_b    = in_xfer && load_ok && (in_data_i.cmd == CMD_LOAD_B);
  assign waddr   = AW'(int'(in_data_i.row_index) * CAP + int'(in_data_i.col_index));

  // A is read along row i, B down column j
  assign raddr_a = AW'(int'(i_q) * CAP + int'(k_q));
  assign raddr_b = AW'(int'(k_q) * CAP + int'(j_q));

  mm_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (in_data_i.elem_value),
    .re_i    (rd_en),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mm_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (in_data_i.elem_value),
    .re_i    (rd_en),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  mm_mac #(
    .FRAC_BITS (FRAC_BITS),
    .ACC_W     (ACC_W)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (rd_ctrl_q),
    .a_i      (signed'(rdata_a)),
    .b_i      (signed'(rdata_b)),
    .done_o   (mac_done),
    .result_o (mac_result)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (mac_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = (i_last && j_last) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    rd_en       = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o  = 1'b1;
      ST_ISSUE: rd_en       = 1'b1;
      ST_DRAIN: ;
      ST_OUT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_ctrl_q <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      nr_q      <= DIM_W'(1);
      nk_q      <= DIM_W'(1);
      nc_q      <= DIM_W'(1);
    end else begin
      state_q         <= state_d;
      // Tag each read so the MAC knows where an element starts and ends
      rd_ctrl_q.valid <= rd_en;
      rd_ctrl_q.first <= (k_q == '0);
      rd_ctrl_q.last  <= k_last;
      if (start) begin
        nr_q <= eff_dim(rows_a_q);
        nk_q <= eff_dim(inner_dim_q);
        nc_q <= eff_dim(cols_b_q);
        i_q  <= '0;
        j_q  <= '0;
        k_q  <= '0;
      end
      if (rd_en) begin
        k_q <= k_last ? '0 : k_q + IDX_W'(1);
      end
      // Advance to the next element once the current one is transferred
      if (out_xfer) begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + IDX_W'(1);
        end else begin
          j_q <= j_q + IDX_W'(1);
        end
      end
    end
  end

  // Output register: hold the finished element until transferred
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN && mac_done) begin
      out_q.out_row   <= 3'(i_q);
      out_q.out_col   <= 3'(j_q);
      out_q.out_value <= mac_result;
      out_q.last      <= i_last && j_last;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

FILE: rtl/mm_ram.sv
`default_nettype none

module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/mm_mac.sv
`default_nettype none

module mm_mac #(
  parameter int FRAC_BITS = 16,
  parameter int ACC_W     = 68
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire mm_pkg::mac_ctrl_t       ctrl_i,
  input  wire logic signed [31:0]      a_i,
  input  wire logic signed [31:0]      b_i,
  output logic                         done_o,
  output logic signed [31:0]           result_o
);

  import mm_pkg::*;

  mac_ctrl_t                 p_ctrl_q;
  logic signed [63:0]        prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic                      done_q;
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-32:0]         upper;
  logic                      fits;

  // Multiply stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_ctrl_q <= '0;
    end else begin
      p_ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.valid) begin
      prod_q <= a_i * b_i;
    end
  end

  // Accumulate stage: restart the sum on the first term of an element
  always_comb begin
    acc_d = acc_q;
    if (p_ctrl_q.valid) begin
      if (p_ctrl_q.first) begin
        acc_d = ACC_W'(prod_q);
      end else begin
        acc_d = acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      done_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      done_q <= p_ctrl_q.valid && p_ctrl_q.last;
    end
  end

  // Drop the fraction bits (floor) and clamp to the 32-bit range
  assign shifted = acc_q >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:31];
  assign fits    = (&upper) || !(|upper);

  always_comb begin
    if (fits) begin
      result_o = shifted[31:0];
    end else if (acc_q[ACC_W-1]) begin
      result_o = 32'sh8000_0000;
    end else begin
      result_o = 32'sh7FFF_FFFF;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: tb/matrix_multiply_tb.sv
`timescale 1ns / 1ps

module matrix_multiply_tb;
  import mm_pkg::*;

  localparam int MAX_DIM   = 8;
  localparam int FRAC_BITS = 16;
  // Largest usable dimension, whatever the registers say
  localparam int DIM_CAP   = (MAX_DIM < 8) ? MAX_DIM : 8;

  // Command code with no meaning; the block must drop it
  localparam logic [1:0] CMD_UNDEF = 2'd3;
  // Register index past the last dimension register; writes to it are dropped
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int RANDOM_ITEMS   = 470;
  // Long receiver hold-off that forces the block to back up onto its input
  localparam int RX_HOLD_CYCLES = 500;
  // Let a load still inside the block finish before touching the registers
  localparam int SETTLE_CYCLES  = 16;
  // Worst quiet stretch is the hold-off above; allow several times that
  localparam int WATCHDOG_LIMIT = 4000;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [3:0] cfg_data = '0;

  always #1 clk = ~clk;

  matrix_multiply #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Own copy of the block's state: both operand stores, which entries hold a
  // loaded value, and the three dimension registers (reset value 1)
  logic signed [31:0] mat_a [MAX_DIM*MAX_DIM];
  logic signed [31:0] mat_b [MAX_DIM*MAX_DIM];
  bit [MAX_DIM*MAX_DIM-1:0] a_loaded = '0;
  bit [MAX_DIM*MAX_DIM-1:0] b_loaded = '0;
  logic [3:0] dim_reg [3] = '{4'd1, 4'd1, 4'd1};

  // Product elements still owed by the block, oldest first
  out_item_t pending_elems [$];

  int unsigned fault_count = 0;
  int unsigned idle_cycles = 0;
  bit          rx_hold_req = 1'b0;

  // Opening probes, run with the reset dimensions (1 x 1 x 1). Where the
  // product is obvious it is typed in; the rest go through the predictor.
  typedef struct packed {
    in_item_t    item;
    logic        typed;
    logic [31:0] want;
  } probe_row_t;

  probe_row_t probe_tab [21] = '{
    // 1.0 * 2.0
    '{'{CMD_LOAD_A,  3'd0, 3'd0, 32'h0001_0000}, 1'b0, 32'h0},
    '{'{CMD_LOAD_B,  3'd0, 3'd0, 32'h0002_0000}, 1'b0, 32'h0},
    '{'{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000}, 1'b1, 32'h0002_0000},
    // max * max saturates high
    '{'{CMD_LOAD_A,  3'd0, 3'd0, 32'h7FFF_FFFF}, 1'b0, 32'h0},
    '{'{CMD_LOAD_B,  3'd0, 3'd0, 32'h7FFF_FFFF}, 1'b0, 32'h0},
    '{'{CMD_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF}, 1'b1, 32'h7FFF_FFFF},
    // min * max saturates low
    '{'{CMD_LOAD_A,  3'd0, 3'd0, 32'h8000_0000}, 1'b0, 32'h0},
    '{'{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000}, 1'b1, 32'h8000_0000},
    // min * min is +2^62, saturates high
    '{'{CMD_LOAD_B,  3'd0, 3'd0, 32'h8000_0000}, 1'b0, 32'h0},
    '{'{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000}, 1'b1, 32'h7FFF_FFFF},
    // tiny negative product rounds towards minus infinity, not to zero
    '{'{CMD_LOAD_A,  3'd0, 3'd0, 32'hFFFF_FFFF}, 1'b0, 32'h0},
    '{'{CMD_LOAD_B,  3'd0, 3'd0, 32'h0000_0001}, 1'b0, 32'h0},
    '{'{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000}, 1'b1, 32'hFFFF_FFFF},
    // tiny positive product truncates to zero
    '{'{CMD_LOAD_B,  3'd0, 3'd0, 32'hFFFF_FFFF}, 1'b0, 32'h0},
    '{'{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000}, 1'b1, 32'h0000_0000},
    // undefined command is dropped
    '{'{CMD_UNDEF,   3'd7, 3'd7, 32'hFFFF_FFFF}, 1'b0, 32'h0},
    // far corner of both stores
    '{'{CMD_LOAD_A,  3'd7, 3'd7, 32'h5555_AAAA}, 1'b0, 32'h0},
    '{'{CMD_LOAD_B,  3'd7, 3'd7, 32'hAAAA_5555}, 1'b0, 32'h0},
    // 3.0 * -1 lsb gives exactly -3 lsb
    '{'{CMD_LOAD_A,  3'd0, 3'd0, 32'h0003_0000}, 1'b0, 32'h0},
    '{'{CMD_COMPUTE, 3'd0, 3'd0, 32'h0000_0000}, 1'b1, 32'hFFFF_FFFD},
    '{'{CMD_COMPUTE, 3'd5, 3'd2, 32'h1234_5678}, 1'b0, 32'h0}
  };

  task automatic report_fault(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fault_count++;
  endtask

  // Register value as the block uses it: zero counts as one, cap at DIM_CAP
  function automatic int unsigned eff_dim(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > DIM_CAP) return DIM_CAP;
    return 32'(v);
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Element values: raw bit patterns, small Q16.16 numbers and the edges
  function automatic logic signed [31:0] rand_elem();
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      6: begin
        case ($urandom_range(0, 4))
          0: return Q_MAX;
          1: return Q_MIN;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  // Track one accepted transfer: update the stores, or work out every element
  // of C the block must send back for a compute command.
  task automatic predict_elems(input in_item_t it);
    logic signed [63:0] prod;
    logic signed [71:0] acc;
    logic signed [71:0] scaled;
    out_item_t          elem;
    int unsigned        nr, nk, nc, idx;
    idx = int'(it.row_index) * MAX_DIM + int'(it.col_index);
    case (it.cmd)
      CMD_LOAD_A: begin
        mat_a[idx]    = it.elem_value;
        a_loaded[idx] = 1'b1;
      end
      CMD_LOAD_B: begin
        mat_b[idx]    = it.elem_value;
        b_loaded[idx] = 1'b1;
      end
      CMD_COMPUTE: begin
        nr = eff_dim(dim_reg[REG_ROWS_A]);
        nk = eff_dim(dim_reg[REG_INNER_DIM]);
        nc = eff_dim(dim_reg[REG_COLS_B]);
        for (int unsigned i = 0; i < nr; i++) begin
          for (int unsigned j = 0; j < nc; j++) begin
            acc = '0;
            for (int unsigned k = 0; k < nk; k++) begin
              prod = mat_a[i*MAX_DIM+k] * mat_b[k*MAX_DIM+j];
              acc  = acc + prod;
            end
            // Arithmetic shift drops the fraction towards minus infinity
            scaled = acc >>> FRAC_BITS;
            elem.out_row = i[2:0];
            elem.out_col = j[2:0];
            if (scaled > Q_MAX) elem.out_value = Q_MAX;
            else if (scaled < Q_MIN) elem.out_value = Q_MIN;
            else elem.out_value = scaled[31:0];
            elem.last = (i == nr - 1) && (j == nc - 1);
            pending_elems.push_back(elem);
          end
        end
      end
      default: begin
        // undefined command: nothing changes, nothing comes back
      end
    endcase
  endtask

  // Offer one input transfer and return at the edge that takes it. Valid is
  // left high so a following item can go out back to back.
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid for a few cycles after a transfer
  task automatic hold_off(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx != REG_SPARE) dim_reg[idx] = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stop offering, wait for every owed element, then give any trailing load
  // time to retire before the registers are touched.
  task automatic settle_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random back-pressure, short stalls mostly, long ones now and
  // then, plus one long hold-off on request from the stimulus.
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 99) < 35) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  // Compare each output transfer against the oldest owed element
  always @(posedge clk) begin : check_out
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_elems.size() == 0) begin
        report_fault($sformatf("unexpected element row %0d col %0d value %h",
                               out_data.out_row, out_data.out_col, out_data.out_value));
      end else begin
        want = pending_elems.pop_front();
        if (out_data.out_row !== want.out_row)
          report_fault($sformatf("out_row %0d, want %0d", out_data.out_row, want.out_row));
        if (out_data.out_col !== want.out_col)
          report_fault($sformatf("out_col %0d, want %0d", out_data.out_col, want.out_col));
        if (out_data.out_value !== want.out_value)
          report_fault($sformatf("element %0d,%0d out_value %h, want %h", want.out_row,
                                 want.out_col, out_data.out_value, want.out_value));
        if (out_data.last !== want.last)
          report_fault($sformatf("element %0d,%0d last %b, want %b", want.out_row,
                                 want.out_col, out_data.last, want.last));
      end
    end
  end

  // Watchdog: count cycles with no transfer on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t    it;
    int unsigned phase, runs, run_goal, items_sent, nr, nk, nc, roll;
    bit          burst, ready_ab, found;
    logic [3:0]  dr, dk, dc;

    items_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Opening probes with the reset dimensions
    foreach (probe_tab[n]) begin
      send_item(probe_tab[n].item);
      if (probe_tab[n].typed)
        pending_elems.push_back('{3'd0, 3'd0, probe_tab[n].want, 1'b1});
      else
        predict_elems(probe_tab[n].item);
      hold_off(gap_len());
    end

    // Random phases: set the dimensions while idle, then load operands and
    // run products until the phase has done its share of compute commands.
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      settle_idle();
      case (phase)
        0: {dr, dk, dc} = {4'd0, 4'd0, 4'd0};
        1: {dr, dk, dc} = {4'd8, 4'd8, 4'd8};
        2: {dr, dk, dc} = {4'd15, 4'd15, 4'd15};
        3: {dr, dk, dc} = {4'd1, 4'd8, 4'd1};
        4: {dr, dk, dc} = {4'd8, 4'd1, 4'd8};
        default: begin
          if ($urandom_range(0, 4) == 0) begin
            dr = 4'($urandom_range(0, 15));
            dk = 4'($urandom_range(0, 15));
            dc = 4'($urandom_range(0, 15));
          end else begin
            dr = 4'($urandom_range(1, 4));
            dk = 4'($urandom_range(1, 4));
            dc = 4'($urandom_range(1, 4));
          end
        end
      endcase
      write_reg(REG_ROWS_A, dr);
      write_reg(REG_INNER_DIM, dk);
      write_reg(REG_COLS_B, dc);
      if (phase == 0) write_reg(REG_SPARE, 4'($urandom_range(0, 15)));
      nr = eff_dim(dr);
      nk = eff_dim(dk);
      nc = eff_dim(dc);

      burst    = ($urandom_range(0, 3) == 0);
      run_goal = $urandom_range(1, 3);
      runs     = 0;
      while (runs < run_goal && items_sent < RANDOM_ITEMS) begin
        // A product may only read entries that have been loaded
        ready_ab = 1'b1;
        for (int unsigned i = 0; i < nr; i++)
          for (int unsigned k = 0; k < nk; k++)
            if (!a_loaded[i*MAX_DIM+k]) ready_ab = 1'b0;
        for (int unsigned k = 0; k < nk; k++)
          for (int unsigned j = 0; j < nc; j++)
            if (!b_loaded[k*MAX_DIM+j]) ready_ab = 1'b0;

        it.row_index  = 3'($urandom_range(0, 7));
        it.col_index  = 3'($urandom_range(0, 7));
        it.elem_value = rand_elem();
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          it.cmd = CMD_UNDEF;
        end else if (ready_ab && roll < 30) begin
          it.cmd = CMD_COMPUTE;
        end else begin
          it.cmd = $urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B;
          if (!ready_ab && $urandom_range(0, 9) < 8) begin
            // Aim at a hole the next product would read
            found = 1'b0;
            for (int unsigned i = 0; i < nr && !found; i++)
              for (int unsigned k = 0; k < nk && !found; k++)
                if (!a_loaded[i*MAX_DIM+k]) begin
                  it.cmd       = CMD_LOAD_A;
                  it.row_index = i[2:0];
                  it.col_index = k[2:0];
                  found        = 1'b1;
                end
            for (int unsigned k = 0; k < nk && !found; k++)
              for (int unsigned j = 0; j < nc && !found; j++)
                if (!b_loaded[k*MAX_DIM+j]) begin
                  it.cmd       = CMD_LOAD_B;
                  it.row_index = k[2:0];
                  it.col_index = j[2:0];
                  found        = 1'b1;
                end
          end else if ($urandom_range(0, 1)) begin
            // Overwrite inside the region in use so the products keep changing
            if (it.cmd == CMD_LOAD_A) begin
              it.row_index = 3'($urandom_range(0, nr - 1));
              it.col_index = 3'($urandom_range(0, nk - 1));
            end else begin
              it.row_index = 3'($urandom_range(0, nk - 1));
              it.col_index = 3'($urandom_range(0, nc - 1));
            end
          end
        end

        // On the first full-size product, hold the receiver off so the block
        // backs up and stalls the input while loads keep coming
        if (phase == 1 && runs == 0 && it.cmd == CMD_COMPUTE) rx_hold_req = 1'b1;
        if (it.cmd == CMD_COMPUTE) runs++;
        items_sent++;

        send_item(it);
        predict_elems(it);
        hold_off(burst ? 0 : gap_len());
      end
      phase++;
    end

    settle_idle();
    if (fault_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
